// ===== src/tcw_pkg.sv =====
// tcw_pkg: shared types and constants for the text console writer.
// Holds the cell layout, operation codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package tcw_pkg;

    localparam logic [7:0] SPACE_CODE    = 8'd32;
    localparam logic [7:0] NEWLINE_CODE  = 8'd10;
    localparam logic [7:0] DEFAULT_COLOR = 8'd14;

    typedef enum logic [1:0] {
        OP_PUT   = 2'd0,
        OP_SET   = 2'd1,
        OP_CLEAR = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    localparam logic REG_TEXT_COLOR    = 1'b0;
    localparam logic REG_SCROLL_ENABLE = 1'b1;

    // One screen cell: character code and colour code.
    typedef struct packed {
        logic [7:0] ch;
        logic [7:0] color;
    } cell_t;

endpackage

// ===== src/tcw_ram.sv =====
// tcw_ram: screen store, one cell (character and colour) per entry.
// One write port and one registered read port. Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_ram
    import tcw_pkg::*;
#(
    parameter int DEPTH  = 1000,
    parameter int ADDR_W = 10
)
(
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  cell_t             wr_cell,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output cell_t             rd_cell
);

    cell_t mem [DEPTH];
    cell_t rd_cell_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_cell;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_cell_reg <= mem[rd_addr];
        end
    end

    assign rd_cell = rd_cell_reg;

endmodule

// ===== src/tcw_seq.sv =====
// tcw_seq: sequencer, cursor state and shared address adder of the console.
// Drives the screen store for put, clear, scroll, read and the reset sweep.
// Depends on tcw_pkg.
`timescale 1ns / 1ps

module tcw_seq
    import tcw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 40,
    parameter int SCREEN_HEIGHT = 25,
    parameter int COL_W         = 6,
    parameter int ROW_W         = 5,
    parameter int ADDR_W        = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [1:0]        op,
    input  logic [7:0]        char_code,
    input  logic [7:0]        col,
    input  logic [7:0]        row,
    input  logic [7:0]        text_color,
    input  logic              scroll_enable,
    output logic              res_valid,
    input  logic              res_ready,
    output logic [COL_W-1:0]  res_cursor_col,
    output logic [ROW_W-1:0]  res_cursor_row,
    output cell_t             res_cell,
    output logic              wr_en,
    output logic [ADDR_W-1:0] wr_addr,
    output cell_t             wr_cell,
    output logic              rd_en,
    output logic [ADDR_W-1:0] rd_addr,
    input  cell_t             rd_cell
);

    localparam int CELLS = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam logic [ADDR_W-1:0] W_A        = ADDR_W'(SCREEN_WIDTH);
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(CELLS - 1);
    localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - SCREEN_WIDTH);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(SCREEN_HEIGHT - 1);

    typedef enum logic [5:0] {
        ST_INIT   = 6'b000001,
        ST_IDLE   = 6'b000010,
        ST_READ   = 6'b000100,
        ST_SCROLL = 6'b001000,
        ST_FILL   = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] cnt_reg, cnt_next;
    logic              pend_reg, pend_next;
    logic [ADDR_W-1:0] pend_addr_reg, pend_addr_next;
    logic [COL_W-1:0]  cur_col_reg, cur_col_next;
    logic [ROW_W-1:0]  cur_row_reg, cur_row_next;
    cell_t             res_cell_reg, res_cell_next;

    logic              accept;
    logic [ROW_W-1:0]  mul_row;
    logic [ADDR_W-1:0] mul_col;
    logic [ADDR_W-1:0] opa;
    logic [ADDR_W-1:0] opb;
    logic [ADDR_W-1:0] sum;
    logic [COL_W:0]    col_inc;
    logic [ROW_W:0]    row_inc;
    logic              col_ok;
    logic              row_ok;

    assign accept   = in_valid && (state_reg == ST_IDLE);
    assign in_stall = (state_reg != ST_IDLE);

    assign col_ok = (col < 8'(SCREEN_WIDTH));
    assign row_ok = (row < 8'(SCREEN_HEIGHT));

    // Shared address adder: cell address row * width + col in idle,
    // copy source cnt + width while scrolling.
    assign mul_row = (op == OP_READ) ? row[ROW_W-1:0] : cur_row_reg;
    assign mul_col = (op == OP_READ) ? ADDR_W'(col) : ADDR_W'(cur_col_reg);
    assign opa = (state_reg == ST_IDLE) ? ADDR_W'(ADDR_W'(mul_row) * W_A) : cnt_reg;
    assign opb = (state_reg == ST_IDLE) ? mul_col : W_A;
    assign sum = opa + opb;

    assign col_inc = {1'b0, cur_col_reg} + (COL_W+1)'(1);
    assign row_inc = {1'b0, cur_row_reg} + (ROW_W+1)'(1);

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        pend_next      = 1'b0;
        pend_addr_next = pend_addr_reg;
        cur_col_next   = cur_col_reg;
        cur_row_next   = cur_row_reg;
        res_cell_next  = res_cell_reg;
        wr_en          = 1'b0;
        wr_addr        = cnt_reg;
        wr_cell        = '{ch: SPACE_CODE, color: text_color};
        rd_en          = 1'b0;
        rd_addr        = sum;

        // Pending scroll copy: read data from the previous cycle lands here.
        if (pend_reg)
        begin
            wr_en   = 1'b1;
            wr_addr = pend_addr_reg;
            wr_cell = rd_cell;
        end

        unique case (state_reg)
            ST_INIT:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_cell = '{ch: SPACE_CODE, color: DEFAULT_COLOR};
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    res_cell_next = '0;
                    state_next    = ST_DONE;
                    unique case (op)
                        OP_PUT:
                        begin
                            if (char_code != NEWLINE_CODE)
                            begin
                                wr_en   = 1'b1;
                                wr_addr = sum;
                                wr_cell = '{ch: char_code, color: text_color};
                            end
                            if ((char_code == NEWLINE_CODE) ||
                                (col_inc >= (COL_W+1)'(SCREEN_WIDTH)))
                            begin
                                cur_col_next = '0;
                                if (row_inc >= (ROW_W+1)'(SCREEN_HEIGHT))
                                begin
                                    if (scroll_enable)
                                    begin
                                        cur_row_next = LAST_ROW;
                                        cnt_next     = '0;
                                        state_next   = ST_SCROLL;
                                    end
                                    else
                                    begin
                                        cur_row_next = '0;
                                    end
                                end
                                else
                                begin
                                    cur_row_next = row_inc[ROW_W-1:0];
                                end
                            end
                            else
                            begin
                                cur_col_next = col_inc[COL_W-1:0];
                            end
                        end
                        OP_SET:
                        begin
                            cur_col_next = col_ok ? col[COL_W-1:0] : '0;
                            cur_row_next = row_ok ? row[ROW_W-1:0] : '0;
                        end
                        OP_CLEAR:
                        begin
                            cur_col_next = '0;
                            cur_row_next = '0;
                            cnt_next     = '0;
                            state_next   = ST_FILL;
                        end
                        OP_READ:
                        begin
                            if (col_ok && row_ok)
                            begin
                                rd_en      = 1'b1;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            state_next = ST_DONE;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                res_cell_next = rd_cell;
                state_next    = ST_DONE;
            end
            ST_SCROLL:
            begin
                // Move each cell up one row, reading it in the cycle before its write.
                if (cnt_reg != COPY_END)
                begin
                    rd_en          = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = cnt_reg;
                    cnt_next       = cnt_reg + ADDR_W'(1);
                end
                else
                begin
                    state_next = ST_FILL;
                end
            end
            ST_FILL:
            begin
                wr_en   = 1'b1;
                wr_addr = cnt_reg;
                wr_cell = '{ch: SPACE_CODE, color: text_color};
                if (cnt_reg == LAST_ADDR)
                begin
                    cnt_next   = '0;
                    state_next = ST_DONE;
                end
                else
                begin
                    cnt_next = cnt_reg + ADDR_W'(1);
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            cnt_reg     <= '0;
            pend_reg    <= 1'b0;
            cur_col_reg <= '0;
            cur_row_reg <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            pend_reg    <= pend_next;
            cur_col_reg <= cur_col_next;
            cur_row_reg <= cur_row_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= pend_addr_next;
        res_cell_reg  <= res_cell_next;
    end

    assign res_valid      = (state_reg == ST_DONE);
    assign res_cursor_col = cur_col_reg;
    assign res_cursor_row = cur_row_reg;
    assign res_cell       = res_cell_reg;

endmodule

// ===== src/text_console_writer_core.sv =====
// text_console_writer_core: top level of the character-cell text console.
// Instantiates tcw_seq and tcw_ram; holds config and output registers.
// Depends on tcw_pkg.
//
// Usage:
//   Input channel (in_valid / in_stall) carries one operation per transaction:
//   op, char_code, col, row. Output channel (out_valid / out_stall) returns one
//   result per operation: cursor_col, cursor_row, cell_char, cell_color.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes
//   text_color (index 0) and scroll_enable (index 1, bit 0); always ready.
//   Write config only while no operation is in flight.
// Path from accept to out_valid, set by the single store port pair and the
// sweep counter (states of tcw_seq, then the output register):
//   put char / set cursor / out-of-range read: IDLE, DONE.
//   read cell: IDLE, READ, DONE. clear screen: IDLE, FILL over W*H cells, DONE.
//   put char that scrolls: IDLE, SCROLL (copy rows up), FILL (last row), DONE.
//   in_stall stays high from acceptance until the result is loaded.
// Reset: cursor to origin, text_color 14, scroll_enable 1. A sweep over all W*H
//   cells (1000 by default) then fills the store with spaces in colour 14;
//   in_stall is high during that sweep.
// Stall: a stalled result holds in the output register; the sequencer waits
//   with its finished result until the output register frees up.
`timescale 1ns / 1ps

module text_console_writer_core
    import tcw_pkg::*;
#(
    parameter int SCREEN_WIDTH  = 40,
    parameter int SCREEN_HEIGHT = 25
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [1:0]                       op,
    input  logic [7:0]                       char_code,
    input  logic [7:0]                       col,
    input  logic [7:0]                       row,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [$clog2(SCREEN_WIDTH)-1:0]  cursor_col,
    output logic [$clog2(SCREEN_HEIGHT)-1:0] cursor_row,
    output logic [7:0]                       cell_char,
    output logic [7:0]                       cell_color,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic                             cfg_index,
    input  logic [7:0]                       cfg_data
);

    localparam int COL_W  = $clog2(SCREEN_WIDTH);
    localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
    localparam int CELLS  = SCREEN_WIDTH * SCREEN_HEIGHT;
    localparam int ADDR_W = $clog2(CELLS);

    logic [7:0]        text_color_reg;
    logic              scroll_enable_reg;

    logic              out_valid_reg;
    logic [COL_W-1:0]  cursor_col_reg;
    logic [ROW_W-1:0]  cursor_row_reg;
    cell_t             cell_reg;

    logic              res_valid;
    logic              res_ready;
    logic              res_load;
    logic [COL_W-1:0]  res_cursor_col;
    logic [ROW_W-1:0]  res_cursor_row;
    cell_t             res_cell;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    cell_t             wr_cell;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    cell_t             rd_cell;

    // Config registers: always ready.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_color_reg    <= DEFAULT_COLOR;
            scroll_enable_reg <= 1'b1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_TEXT_COLOR:    text_color_reg    <= cfg_data;
                REG_SCROLL_ENABLE: scroll_enable_reg <= cfg_data[0];
                default:           text_color_reg    <= text_color_reg;
            endcase
        end
    end

    tcw_seq #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT),
        .COL_W         (COL_W),
        .ROW_W         (ROW_W),
        .ADDR_W        (ADDR_W)
    ) u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .op             (op),
        .char_code      (char_code),
        .col            (col),
        .row            (row),
        .text_color     (text_color_reg),
        .scroll_enable  (scroll_enable_reg),
        .res_valid      (res_valid),
        .res_ready      (res_ready),
        .res_cursor_col (res_cursor_col),
        .res_cursor_row (res_cursor_row),
        .res_cell       (res_cell),
        .wr_en          (wr_en),
        .wr_addr        (wr_addr),
        .wr_cell        (wr_cell),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .rd_cell        (rd_cell)
    );

    tcw_ram #(
        .DEPTH  (CELLS),
        .ADDR_W (ADDR_W)
    ) u_ram (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_cell (wr_cell),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_cell (rd_cell)
    );

    // Output register: load when empty or when the current result leaves.
    assign res_ready = !out_valid_reg || !out_stall;
    assign res_load  = res_valid && res_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_load)
        begin
            cursor_col_reg <= res_cursor_col;
            cursor_row_reg <= res_cursor_row;
            cell_reg       <= res_cell;
        end
    end

    assign out_valid  = out_valid_reg;
    assign cursor_col = cursor_col_reg;
    assign cursor_row = cursor_row_reg;
    assign cell_char  = cell_reg.ch;
    assign cell_color = cell_reg.color;

endmodule

// ===== src/tcw_checker.sv =====
// tcw_checker: port-level assertions for text_console_writer_core.
// Bound to the top level below; no package dependency.
`timescale 1ns / 1ps

module tcw_checker
#(
    parameter int SCREEN_WIDTH  = 40,
    parameter int SCREEN_HEIGHT = 25
)
(
    input logic                             clk,
    input logic                             rst_n,
    input logic                             in_valid,
    input logic                             in_stall,
    input logic                             out_valid,
    input logic                             out_stall,
    input logic [$clog2(SCREEN_WIDTH)-1:0]  cursor_col,
    input logic [$clog2(SCREEN_HEIGHT)-1:0] cursor_row,
    input logic [7:0]                       cell_char,
    input logic [7:0]                       cell_color
);

    // The block works on one transaction at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("input accepted while previous transaction in flight");

    // A new result never appears in the cycle after a transaction is taken.
    a_no_result_on_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> !out_valid || $past(out_valid))
        else $error("result appeared one cycle after acceptance");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_col < SCREEN_WIDTH)
        else $error("cursor column out of range");

    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> cursor_row < SCREEN_HEIGHT)
        else $error("cursor row out of range");

    a_hold_stalled: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(cursor_col)
            && $stable(cursor_row) && $stable(cell_char) && $stable(cell_color))
        else $error("stalled result changed");

endmodule

bind text_console_writer_core tcw_checker #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .cell_char  (cell_char),
    .cell_color (cell_color)
);

// ===== tb/sv/testbench.sv =====
// testbench: self-checking bench for text_console_writer_core.
// Drives console operations and register writes, checks each result against a local
// screen model. Depends on tcw_pkg and text_console_writer_core.
`timescale 1ns / 1ps

module testbench;
    import tcw_pkg::*;

    localparam int SCREEN_W    = 40;
    localparam int SCREEN_H    = 25;
    localparam int CELLS       = SCREEN_W * SCREEN_H;
    localparam int COL_W       = $clog2(SCREEN_W);
    localparam int ROW_W       = $clog2(SCREEN_H);
    // A scroll or a clear sweeps the whole screen; allow that plus some slack.
    localparam int SWEEP_SLACK = CELLS + 16;
    // The worst run is every item scrolling behind long output stalls; take it
    // several times over.
    localparam int CYCLE_LIMIT = 3_000_000;

    // Cursor position and the cell read back, as the block reports them.
    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [7:0]       ch;
        logic [7:0]       color;
    } console_result_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             in_valid = 1'b0;
    logic             in_stall;
    logic [1:0]       op = OP_PUT;
    logic [7:0]       char_code = '0;
    logic [7:0]       col = '0;
    logic [7:0]       row = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    logic [COL_W-1:0] cursor_col;
    logic [ROW_W-1:0] cursor_row;
    logic [7:0]       cell_char;
    logic [7:0]       cell_color;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic             cfg_index = REG_TEXT_COLOR;
    logic [7:0]       cfg_data = '0;

    // Local copy of the screen, cursor and registers.
    logic [7:0]       screen_char [CELLS];
    logic [7:0]       screen_color [CELLS];
    int               cur_x;
    int               cur_y;
    logic [7:0]       text_color_q;
    logic             scroll_on;

    console_result_t  expected_results[$];
    int               err_cnt = 0;
    int               cycle_cnt = 0;
    int               send_idle_pct = 0;
    int               recv_stall_pct = 0;

    text_console_writer_core #(
        .SCREEN_WIDTH  (SCREEN_W),
        .SCREEN_HEIGHT (SCREEN_H)
    ) dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .op         (op),
        .char_code  (char_code),
        .col        (col),
        .row        (row),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .cursor_col (cursor_col),
        .cursor_row (cursor_row),
        .cell_char  (cell_char),
        .cell_color (cell_color),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // Drop the run if it hangs; the fail line is the only output then.
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Move the cursor to the start of the next row; at the bottom either
    // scroll the screen up and blank the new last row, or jump to the origin.
    function automatic void advance_row();
        cur_x = 0;
        cur_y++;
        if (cur_y >= SCREEN_H)
        begin
            if (scroll_on)
            begin
                for (int i = 0; i < CELLS - SCREEN_W; i++)
                begin
                    screen_char[i]  = screen_char[i + SCREEN_W];
                    screen_color[i] = screen_color[i + SCREEN_W];
                end
                for (int i = CELLS - SCREEN_W; i < CELLS; i++)
                begin
                    screen_char[i]  = SPACE_CODE;
                    screen_color[i] = text_color_q;
                end
                cur_y = SCREEN_H - 1;
            end
            else
            begin
                cur_y = 0;
            end
        end
    endfunction

    // Apply one operation to the local screen and return what the block
    // should report for it.
    function automatic console_result_t apply_console_op(op_t kind, logic [7:0] ch,
                                                         logic [7:0] c, logic [7:0] r);
        console_result_t res;
        int              idx;
        res = '0;
        case (kind)
            OP_PUT:
            begin
                if (ch == NEWLINE_CODE)
                begin
                    advance_row();
                end
                else
                begin
                    idx = cur_y * SCREEN_W + cur_x;
                    screen_char[idx]  = ch;
                    screen_color[idx] = text_color_q;
                    cur_x++;
                    if (cur_x >= SCREEN_W)
                        advance_row();
                end
            end
            OP_SET:
            begin
                cur_x = (c >= SCREEN_W) ? 0 : int'(c);
                cur_y = (r >= SCREEN_H) ? 0 : int'(r);
            end
            OP_CLEAR:
            begin
                for (int i = 0; i < CELLS; i++)
                begin
                    screen_char[i]  = SPACE_CODE;
                    screen_color[i] = text_color_q;
                end
                cur_x = 0;
                cur_y = 0;
            end
            OP_READ:
            begin
                if (c < SCREEN_W && r < SCREEN_H)
                begin
                    idx = int'(r) * SCREEN_W + int'(c);
                    res.ch    = screen_char[idx];
                    res.color = screen_color[idx];
                end
            end
        endcase
        res.col = cur_x[COL_W-1:0];
        res.row = cur_y[ROW_W-1:0];
        return res;
    endfunction

    // Hold one operation on the input channel until it is accepted, then
    // queue its expected result. Valid stays high on return so a following
    // transaction can go out back to back.
    task automatic send_op(input op_t kind, input logic [7:0] ch,
                           input logic [7:0] c, input logic [7:0] r);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        op        <= kind;
        char_code <= ch;
        col       <= c;
        row       <= r;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(apply_console_op(kind, ch, c, r));
    endtask

    // Idle the input and wait for every outstanding result.
    task automatic wait_for_results();
        in_valid <= 1'b0;
        do
            @(posedge clk);
        while (expected_results.size() != 0);
    endtask

    // Write both registers back to back; the scroll bit rides in bit 0 with
    // random upper bits that the block must ignore.
    task automatic configure(input logic [7:0] color, input logic scroll);
        cfg_valid <= 1'b1;
        cfg_index <= REG_TEXT_COLOR;
        cfg_data  <= color;
        do
            @(posedge clk);
        while (!cfg_ready);
        text_color_q = color;
        cfg_index <= REG_SCROLL_ENABLE;
        cfg_data  <= {7'($urandom_range(127)), scroll};
        do
            @(posedge clk);
        while (!cfg_ready);
        scroll_on = scroll;
        cfg_valid <= 1'b0;
    endtask

    // Compare each accepted result with the oldest expectation, then pick
    // the stall for the next edge.
    always @(posedge clk)
    begin : result_check
        console_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result with nothing expected: col %0d row %0d char %0d color %0d",
                       cursor_col, cursor_row, cell_char, cell_color);
                err_cnt++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (cursor_col !== want.col)
                begin
                    $error("cursor_col: expected %0d, got %0d", want.col, cursor_col);
                    err_cnt++;
                end
                if (cursor_row !== want.row)
                begin
                    $error("cursor_row: expected %0d, got %0d", want.row, cursor_row);
                    err_cnt++;
                end
                if (cell_char !== want.ch)
                begin
                    $error("cell_char: expected %0d, got %0d", want.ch, cell_char);
                    err_cnt++;
                end
                if (cell_color !== want.color)
                begin
                    $error("cell_color: expected %0d, got %0d", want.color, cell_color);
                    err_cnt++;
                end
            end
        end
        out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
    end

    // Reset contents: spaces in the default colour, reads past either edge
    // give zeros.
    task automatic test_reset_state();
        send_op(OP_READ, 8'h00, 8'd0, 8'd0);
        send_op(OP_READ, 8'hff, 8'(SCREEN_W - 1), 8'(SCREEN_H - 1));
        send_op(OP_READ, 8'h00, 8'(SCREEN_W), 8'd0);
        send_op(OP_READ, 8'h00, 8'd0, 8'(SCREEN_H));
        send_op(OP_READ, 8'h00, 8'hff, 8'hff);
    endtask

    // Out-of-range coordinates fall back to 0, each on its own.
    task automatic test_cursor_set();
        send_op(OP_SET, 8'h00, 8'(SCREEN_W - 1), 8'(SCREEN_H - 1));
        send_op(OP_SET, 8'h00, 8'(SCREEN_W), 8'd3);
        send_op(OP_SET, 8'h00, 8'd7, 8'(SCREEN_H));
        send_op(OP_SET, 8'h00, 8'hff, 8'hff);
    endtask

    // Line end wraps to the next row; newline writes nothing.
    task automatic test_put_and_wrap();
        wait_for_results();
        configure(8'hff, 1'b1);
        send_op(OP_SET, 8'h00, 8'(SCREEN_W - 2), 8'd0);
        send_op(OP_PUT, 8'hff, 8'h00, 8'h00);
        send_op(OP_PUT, 8'h00, 8'hff, 8'hff);
        send_op(OP_PUT, NEWLINE_CODE, 8'h00, 8'h00);
        send_op(OP_READ, 8'h00, 8'(SCREEN_W - 2), 8'd0);
        send_op(OP_READ, 8'h00, 8'(SCREEN_W - 1), 8'd0);
    endtask

    // Wrap and newline on the last row scroll the screen up.
    task automatic test_scroll();
        send_op(OP_SET, 8'h00, 8'(SCREEN_W - 1), 8'(SCREEN_H - 1));
        send_op(OP_PUT, 8'h55, 8'h00, 8'h00);
        send_op(OP_READ, 8'h00, 8'(SCREEN_W - 1), 8'(SCREEN_H - 2));
        send_op(OP_PUT, NEWLINE_CODE, 8'h00, 8'h00);
        send_op(OP_READ, 8'h00, 8'd0, 8'(SCREEN_H - 1));
    endtask

    // With scrolling off the cursor returns to the origin, screen untouched.
    task automatic test_wrap_no_scroll();
        wait_for_results();
        configure(8'h00, 1'b0);
        send_op(OP_SET, 8'h00, 8'd0, 8'(SCREEN_H - 1));
        send_op(OP_PUT, NEWLINE_CODE, 8'h00, 8'h00);
        send_op(OP_SET, 8'h00, 8'(SCREEN_W - 1), 8'(SCREEN_H - 1));
        send_op(OP_PUT, 8'haa, 8'h00, 8'h00);
        send_op(OP_READ, 8'h00, 8'(SCREEN_W - 1), 8'(SCREEN_H - 1));
    endtask

    // Clear fills with spaces in the current text colour.
    task automatic test_clear_screen();
        wait_for_results();
        configure(8'h5a, 1'b1);
        send_op(OP_CLEAR, 8'hff, 8'hff, 8'hff);
        send_op(OP_READ, 8'h00, 8'd20, 8'd12);
    endtask

    // Random text: mostly characters with newlines, cursor moves biased to
    // the bottom rows so scrolls happen often, reads, and a rare clear.
    // Registers change every fifty transactions once the block is idle.
    task automatic test_random_traffic(input int count, input int send_pct,
                                       input int recv_pct);
        int         pick;
        logic [7:0] ch;
        logic [7:0] c;
        logic [7:0] r;
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            if (n % 50 == 0)
            begin
                wait_for_results();
                configure(8'($urandom_range(255)), $urandom_range(3) != 0);
            end
            pick = $urandom_range(99);
            ch   = 8'($urandom_range(255));
            c    = 8'($urandom_range(255));
            r    = 8'($urandom_range(255));
            if (pick < 62)
            begin
                if ($urandom_range(99) < 15)
                    ch = NEWLINE_CODE;
                send_op(OP_PUT, ch, c, r);
            end
            else if (pick < 74)
            begin
                if ($urandom_range(99) < 80)
                begin
                    c = 8'($urandom_range(SCREEN_W - 1));
                    r = $urandom_range(1) ? 8'(SCREEN_H - 1 - $urandom_range(1))
                                          : 8'($urandom_range(SCREEN_H - 1));
                end
                send_op(OP_SET, ch, c, r);
            end
            else if (pick < 97)
            begin
                if ($urandom_range(99) < 80)
                begin
                    c = 8'($urandom_range(SCREEN_W - 1));
                    r = 8'($urandom_range(SCREEN_H - 1));
                end
                send_op(OP_READ, ch, c, r);
            end
            else
            begin
                send_op(OP_CLEAR, ch, c, r);
            end
        end
    endtask

    initial
    begin
        for (int i = 0; i < CELLS; i++)
        begin
            screen_char[i]  = SPACE_CODE;
            screen_color[i] = DEFAULT_COLOR;
        end
        cur_x        = 0;
        cur_y        = 0;
        text_color_q = DEFAULT_COLOR;
        scroll_on    = 1'b1;

        // Hold reset, then release; the block sweeps its store before it
        // takes the first transaction.
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        send_idle_pct  = 38;
        recv_stall_pct = 58;
        test_reset_state();
        test_cursor_set();
        test_put_and_wrap();
        test_scroll();
        test_wrap_no_scroll();
        test_clear_screen();

        test_random_traffic(150, 38, 58);
        test_random_traffic(150, 58, 38);
        test_random_traffic(150, 0, 0);

        // Drain, then give any stray result time to show up.
        wait_for_results();
        repeat (SWEEP_SLACK) @(posedge clk);
        if (err_cnt == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== filelist.f =====
src/tcw_pkg.sv
src/tcw_ram.sv
src/tcw_seq.sv
src/text_console_writer_core.sv
src/tcw_checker.sv
tb/sv/testbench.sv
